>>> rtl/lsr_pkg.sv
// Package for the LRU set replacement block: sizes, row types and access kinds.
// Used by lru_set_replacement, lsr_lookup and the testbench; depends on nothing else.
package lsr_pkg;

  localparam int SETS     = 64;
  localparam int WAYS     = 8;
  localparam int TAG_BITS = 20;

  localparam int IN_SET_W   = 6;
  localparam int IN_TAG_W   = 20;
  localparam int OUT_KIND_W = 2;
  localparam int OUT_WAY_W  = 3;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [SET_W-1:0]    set_t;
  typedef logic [WAY_W-1:0]    way_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [WAYS-1:0]     valid_t;
  typedef way_t [WAYS-1:0]     order_t;
  typedef tag_t [WAYS-1:0]     tags_t;

  typedef struct packed {
    valid_t valid;
    order_t order;
  } meta_t;

  typedef enum logic [OUT_KIND_W-1:0] {
    KIND_HIT      = 2'd0,
    KIND_COLD     = 2'd1,
    KIND_CONFLICT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    way_t  way;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  function automatic order_t ident_order();
    order_t o;
    for (int p = 0; p < WAYS; p++) begin
      o[p] = WAY_W'(p);
    end
    return o;
  endfunction

  function automatic set_t wrap_set(logic [IN_SET_W-1:0] v);
    set_t r;
    r = '0;
    for (int i = 0; i < (1 << IN_SET_W); i++) begin
      if (v == IN_SET_W'(i)) begin
        r = SET_W'(i % SETS);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/lru_set_replacement.sv
// Top level of the LRU set replacement block: control, set memories, result register.
// Depends on lsr_pkg, lsr_ram and lsr_lookup.
//
// Usage: each input beat carries a set index and a tag; each produces exactly one
// result beat with the access kind (hit, cold miss, conflict miss) and the way.
// Both channels use valid/ready; a beat moves when valid and ready are both high.
// The set index wraps modulo the set count, and only the low tag bits are kept.
// For each access, the accepting edge starts a read of the set's row from the tag
// RAM and the valid/order RAM; then, in the lookup state, once the result register
// is free, an edge writes the updated row back and loads the result register. The
// read-then-write of one row over the single RAM port pair means that a new beat is
// accepted only after the previous one has been written back. out_valid rises at
// that write-back.
// The result register decouples the channels: a new beat is accepted while a result
// waits; if out_ready stays low the block holds that access in its lookup cycle.
// Reset (rst_n low, synchronous) clears a per-set row-valid flag, so every set then
// reads as all ways invalid with the identity recency order; no clearing pass runs.
module lru_set_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lsr_pkg::IN_SET_W-1:0]    in_set_index,
  input  logic [lsr_pkg::IN_TAG_W-1:0]    in_tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lsr_pkg::OUT_KIND_W-1:0]  out_access_kind,
  output logic [lsr_pkg::OUT_WAY_W-1:0]   out_way
);
  import lsr_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  set_t    set_r;
  tag_t    tag_r;
  logic [SETS-1:0] row_init_r;
  logic    out_valid_r;
  kind_t   kind_r;
  way_t    way_r;

  logic    rd_en;
  logic    wr_en;
  logic    out_free;
  set_t    rd_set;

  meta_t   meta_rdata;
  meta_t   meta_eff;
  meta_t   meta_wdata;
  tags_t   tags_rdata;
  tags_t   tags_wdata;
  result_t res;

  assign out_free = !out_valid_r || out_ready;
  assign rd_set   = wrap_set(in_set_index);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOKUP: wr_en    = out_free;
      default: begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
      end
    endcase
  end

  assign rd_en = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_init_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        row_init_r[set_r] <= 1'b1;
        out_valid_r       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r <= rd_set;
      tag_r <= tag_t'(in_tag);
    end
    if (wr_en) begin
      kind_r <= res.kind;
      way_r  <= res.way;
    end
  end

  lsr_ram #(
    .WIDTH($bits(meta_t)),
    .DEPTH(SETS)
  ) u_meta_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(set_r),
    .wdata(meta_wdata),
    .re   (rd_en),
    .raddr(rd_set),
    .rdata(meta_rdata)
  );

  lsr_ram #(
    .WIDTH($bits(tags_t)),
    .DEPTH(SETS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(set_r),
    .wdata(tags_wdata),
    .re   (rd_en),
    .raddr(rd_set),
    .rdata(tags_rdata)
  );

  always_comb begin
    if (row_init_r[set_r]) begin
      meta_eff = meta_rdata;
    end else begin
      meta_eff.valid = '0;
      meta_eff.order = ident_order();
    end
  end

  lsr_lookup u_lookup (
    .valid    (meta_eff.valid),
    .order    (meta_eff.order),
    .tags     (tags_rdata),
    .tag      (tag_r),
    .res      (res),
    .valid_nxt(meta_wdata.valid),
    .order_nxt(meta_wdata.order),
    .tags_nxt (tags_wdata)
  );

  assign out_valid       = out_valid_r;
  assign out_access_kind = OUT_KIND_W'(kind_r);
  assign out_way         = OUT_WAY_W'(way_r);

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_LOOKUP))
    else $error("accepted beat did not start a lookup");

  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_LOOKUP))
    else $error("result appeared without a lookup");

  a_hit_keeps_tags: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (res.kind == KIND_HIT)) |-> (tags_wdata === tags_rdata))
    else $error("hit changed the stored tags");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_access_kind == KIND_HIT) || (out_access_kind == KIND_COLD) ||
                   (out_access_kind == KIND_CONFLICT)))
    else $error("illegal access kind on output");
`endif

endmodule

>>> rtl/lsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instanced for the tag rows and the valid/order rows.
module lsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lsr_lookup.sv
// Tag match, victim choice and move-to-front update for one set row.
// Depends on lsr_pkg for the row types and access kinds.
module lsr_lookup (
  input  lsr_pkg::valid_t  valid,
  input  lsr_pkg::order_t  order,
  input  lsr_pkg::tags_t   tags,
  input  lsr_pkg::tag_t    tag,
  output lsr_pkg::result_t res,
  output lsr_pkg::valid_t  valid_nxt,
  output lsr_pkg::order_t  order_nxt,
  output lsr_pkg::tags_t   tags_nxt
);
  import lsr_pkg::*;

  valid_t hit_way;
  logic   found;
  way_t   pos;
  way_t   cur;
  way_t   chosen;
  kind_t  kind;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_way[w] = valid[w] && (tags[w] == tag);
    end
  end

  // The first position, most recent first, that holds a hit or an empty way wins.
  always_comb begin
    found = 1'b0;
    pos   = WAY_W'(WAYS - 1);
    kind  = KIND_CONFLICT;
    cur   = '0;
    for (int p = 0; p < WAYS; p++) begin
      cur = order[p];
      if (!found) begin
        if (hit_way[cur]) begin
          found = 1'b1;
          pos   = WAY_W'(p);
          kind  = KIND_HIT;
        end else if (!valid[cur]) begin
          found = 1'b1;
          pos   = WAY_W'(p);
          kind  = KIND_COLD;
        end
      end
    end
  end

  assign chosen = order[pos];

  always_comb begin
    valid_nxt = valid;
    tags_nxt  = tags;
    if (kind != KIND_HIT) begin
      valid_nxt[chosen] = 1'b1;
      tags_nxt[chosen]  = tag;
    end
  end

  always_comb begin
    order_nxt[0] = chosen;
    for (int p = 1; p < WAYS; p++) begin
      order_nxt[p] = (WAY_W'(p) <= pos) ? order[p-1] : order[p];
    end
  end

  assign res.kind = kind;
  assign res.way  = chosen;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for lru_set_replacement: streams cache accesses and checks each
// result beat against a tag/valid/recency predictor kept alongside the block.
// Depends on lsr_pkg and the lru_set_replacement RTL.
`timescale 1ns / 1ps

module testbench;
  import lsr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_TAGS   = 11;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_SET_W-1:0]   in_set_index = '0;
  logic [IN_TAG_W-1:0]   in_tag = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_KIND_W-1:0] out_access_kind;
  logic [OUT_WAY_W-1:0]  out_way;

  logic    cache_valid [SETS][WAYS];
  tag_t    cache_tags  [SETS][WAYS];
  way_t    cache_order [SETS][WAYS];
  result_t pending_results [$];

  logic [IN_TAG_W-1:0] tag_pool [SETS][POOL_TAGS];

  int mismatches = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int rx_mode = 0;
  int rx_hold = 0;
  logic [7:0] rx_phase = '0;

  lru_set_replacement dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_set_index   (in_set_index),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_access_kind(out_access_kind),
    .out_way        (out_way)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_set_replacement verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase == 8'd0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (rx_phase[1:0] == 2'b00);
      end
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else begin
          out_ready <= ~out_ready;
          rx_hold = $urandom_range(0, 20);
        end
      end
    endcase
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat kind %0d way %0d with no access outstanding",
                                  out_access_kind, out_way));
      end else begin
        want = pending_results.pop_front();
        if (out_access_kind !== want.kind) begin
          report_mismatch($sformatf("access_kind %0d, expected %0d", out_access_kind,
                                    want.kind));
        end
        if (out_way !== want.way) begin
          report_mismatch($sformatf("way %0d, expected %0d", out_way, want.way));
        end
      end
    end
  end

  function automatic void clear_cache_model();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        cache_valid[s][w] = 1'b0;
        cache_tags[s][w]  = '0;
        cache_order[s][w] = way_t'(w);
      end
    end
  endfunction

  function automatic result_t lookup_and_update(input logic [IN_SET_W-1:0] set_in,
                                                input logic [IN_TAG_W-1:0] tag_in);
    int      s;
    int      chosen_pos;
    logic    found;
    tag_t    t;
    way_t    w;
    result_t r;
    s = int'(set_in) % SETS;
    t = tag_t'(tag_in);
    found = 1'b0;
    chosen_pos = WAYS - 1;
    r.kind = KIND_CONFLICT;
    r.way = cache_order[s][WAYS-1];
    for (int p = 0; p < WAYS; p++) begin
      w = cache_order[s][p];
      if (!found && cache_valid[s][w] && cache_tags[s][w] == t) begin
        found = 1'b1;
        chosen_pos = p;
        r.kind = KIND_HIT;
        r.way = w;
      end else if (!found && !cache_valid[s][w]) begin
        found = 1'b1;
        chosen_pos = p;
        r.kind = KIND_COLD;
        r.way = w;
        cache_valid[s][w] = 1'b1;
        cache_tags[s][w] = t;
      end
    end
    if (!found) begin
      cache_tags[s][r.way] = t;
    end
    for (int p = chosen_pos; p > 0; p--) begin
      cache_order[s][p] = cache_order[s][p-1];
    end
    cache_order[s][0] = r.way;
    return r;
  endfunction

  task automatic send_access(input logic [IN_SET_W-1:0] set_in,
                             input logic [IN_TAG_W-1:0] tag_in);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_set_index <= set_in;
    in_tag       <= tag_in;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(lookup_and_update(set_in, tag_in));
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_cold_fill_and_hits();
    send_access(6'd0, 20'h00000);
    send_access(6'd0, 20'hFFFFF);
    send_access(6'd0, 20'h00001);
    send_access(6'd0, 20'h00002);
    send_access(6'd0, 20'h80000);
    send_access(6'd0, 20'h55555);
    send_access(6'd0, 20'hAAAAA);
    send_access(6'd0, 20'h00007);
    send_access(6'd0, 20'hFFFFF);
    send_access(6'd0, 20'h00000);
    send_access(6'd0, 20'h00007);
    send_access(6'd0, 20'h12345);
    send_access(6'd0, 20'h00000);
    send_access(6'd0, 20'h00001);
    send_access(6'd0, 20'h00002);
    wait_for_results();
  endtask

  task automatic test_set_and_tag_extremes();
    send_access(6'd63, 20'hFFFFF);
    send_access(6'd63, 20'hFFFFF);
    send_access(6'd63, 20'h00000);
    send_access(6'd32, 20'hAAAAA);
    send_access(6'd31, 20'h55555);
    send_access(6'd0, 20'hFFFFF);
    send_access(6'd63, 20'h00000);
    wait_for_results();
  endtask

  task automatic test_working_set_mix(input int count);
    logic [IN_SET_W-1:0] hot_sets [4];
    logic [IN_SET_W-1:0] s;
    for (int i = 0; i < SETS; i++) begin
      for (int j = 0; j < POOL_TAGS; j++) begin
        tag_pool[i][j] = IN_TAG_W'($urandom);
      end
    end
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        for (int h = 0; h < 4; h++) begin
          hot_sets[h] = IN_SET_W'($urandom_range(0, SETS - 1));
        end
      end
      if (n == count / 2) begin
        wait_for_results();
      end
      if ($urandom_range(0, 9) < 8) begin
        s = hot_sets[$urandom_range(0, 3)];
        send_access(s, tag_pool[s][$urandom_range(0, POOL_TAGS - 1)]);
      end else begin
        send_access(IN_SET_W'($urandom), IN_TAG_W'($urandom));
      end
    end
    wait_for_results();
  endtask

  task automatic test_unbiased_accesses(input int count);
    for (int n = 0; n < count; n++) begin
      send_access(IN_SET_W'($urandom), IN_TAG_W'($urandom));
    end
    wait_for_results();
  endtask

  initial begin
    clear_cache_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cold_fill_and_hits();
    test_set_and_tag_extremes();
    test_working_set_mix(1400);
    test_unbiased_accesses(330);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("lru_set_replacement verification clean");
    end else begin
      $display("lru_set_replacement verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lsr_pkg.sv
rtl/lsr_ram.sv
rtl/lsr_lookup.sv
rtl/lru_set_replacement.sv
verif/testbench.sv
